### src/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared definitions of the LRU key/value cache
// Request codes, sweep operation codes and the status word of the compare
// unit, used by the sequencer and by the compare/rank unit.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    // Request kinds carried on the input word.
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Width of the capacity register write word.
    localparam int CFG_W = 5;

    // Operation applied to the recency ranks during the renumbering pass.
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd0;
    localparam logic [OP_W-1:0] OP_PROMOTE = 2'd1;
    localparam logic [OP_W-1:0] OP_DROP    = 2'd2;
    localparam logic [OP_W-1:0] OP_INSERT  = 2'd3;

    // Status of one entry as seen by the compare unit during the search pass.
    typedef struct packed {
        logic match;   // valid entry holding the requested key
        logic lru;     // valid entry holding the least recent rank
        logic free;    // entry not in use
    } t_scan_hit;

endpackage

### src/lkvc_ram.sv
// ----------------------------------------------------------------------------
// lkvc_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lkvc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/lkvc_rank_unit.sv
// ----------------------------------------------------------------------------
// lkvc_rank_unit: shared compare and rank update unit
// Looks at one entry per cycle: during the search pass it compares the key
// and the rank, during the renumbering pass it computes the new rank.
// ----------------------------------------------------------------------------
module lkvc_rank_unit #(
    parameter int KEY_BITS = 64,
    parameter int RANK_W   = 4
) (
    input  logic [lkvc_pkg::OP_W-1:0] i_op,
    input  logic [RANK_W-1:0]         i_ref_rank,
    input  logic [RANK_W-1:0]         i_lru_rank,
    input  logic [KEY_BITS-1:0]       i_key_req,
    input  logic [KEY_BITS-1:0]       i_key_rd,
    input  logic [RANK_W-1:0]         i_rank_rd,
    input  logic                      i_entry_valid,
    input  logic                      i_is_target,
    output lkvc_pkg::t_scan_hit       o_hit,
    output logic [RANK_W-1:0]         o_new_rank
);

    // Search side: key match, oldest rank and free entry.
    always_comb begin
        o_hit.match = i_entry_valid && (i_key_rd == i_key_req);
        o_hit.lru   = i_entry_valid && (i_rank_rd == i_lru_rank);
        o_hit.free  = !i_entry_valid;
    end

    // Renumbering side: on a promote or insert the touched entry becomes most recent, others shift.
    always_comb begin
        o_new_rank = i_rank_rd;
        if (i_is_target && (i_op == lkvc_pkg::OP_PROMOTE || i_op == lkvc_pkg::OP_INSERT)) begin
            o_new_rank = '0;
        end else if (i_entry_valid) begin
            unique case (i_op)
                lkvc_pkg::OP_PROMOTE: begin
                    if (i_rank_rd < i_ref_rank) begin
                        o_new_rank = i_rank_rd + RANK_W'(1);
                    end
                end
                lkvc_pkg::OP_DROP: begin
                    if (i_rank_rd > i_ref_rank) begin
                        o_new_rank = i_rank_rd - RANK_W'(1);
                    end
                end
                lkvc_pkg::OP_INSERT: begin
                    o_new_rank = i_rank_rd + RANK_W'(1);
                end
                default: begin
                    o_new_rank = i_rank_rd;
                end
            endcase
        end
    end

endmodule

### src/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value store with LRU replacement
// Sequencer, entry state and the key, value and rank memories.
// ----------------------------------------------------------------------------
// One request is handled at a time. A put, or a get or remove that finds its
// key, runs a search pass and then a renumbering pass before the result word
// is loaded; a get or remove that misses, or a word with the unused command
// code, runs the search pass only. The next request is taken once the
// sequencer is back in idle after the result word is loaded. The handling
// time is set by the single read port of the key, value and rank memories:
// one pass over all entries searches for the key, the oldest entry and a
// free slot, and a second pass renumbers the recency ranks, one entry per
// cycle through one compare/rank unit. A finished result waits in
// an output register while the next request is taken. Capacity writes are
// taken at any time but only change the register while the store is empty;
// 0 counts as 1 and values above ENTRIES as ENTRIES.
module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [lkvc_pkg::CMD_W-1:0]   i_cmd,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic [VALUE_BITS-1:0]        i_value,
    // Result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic [VALUE_BITS-1:0]        o_read_value,
    output logic                         o_evicted_valid,
    output logic [KEY_BITS-1:0]          o_victim_key,
    // Capacity register write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lkvc_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                 r_state;
    logic [lkvc_pkg::CMD_W-1:0] r_cmd;
    logic [KEY_BITS-1:0]        r_key;
    logic [VALUE_BITS-1:0]      r_value;

    // Sweep address and read pipeline.
    logic                       r_issue;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_pend;
    logic [IDX_W-1:0]           r_pidx;

    // Search pass results.
    logic                       r_found;
    logic [IDX_W-1:0]           r_slot;
    logic [RANK_W-1:0]          r_slot_rank;
    logic [VALUE_BITS-1:0]      r_rd_value;
    logic                       r_lru_found;
    logic [IDX_W-1:0]           r_lru_slot;
    logic [KEY_BITS-1:0]        r_lru_key;
    logic                       r_free_found;
    logic [IDX_W-1:0]           r_free_slot;

    // Renumbering pass control.
    logic [lkvc_pkg::OP_W-1:0]  r_op;
    logic [IDX_W-1:0]           r_tslot;
    logic [RANK_W-1:0]          r_ref_rank;

    // Result being built and output register.
    logic                       r_hit;
    logic [VALUE_BITS-1:0]      r_res_value;
    logic                       r_ev_valid;
    logic [KEY_BITS-1:0]        r_ev_key;
    logic                       r_out_valid;
    logic                       r_out_hit;
    logic [VALUE_BITS-1:0]      r_out_value;
    logic                       r_out_ev_valid;
    logic [KEY_BITS-1:0]        r_out_ev_key;

    // Entry bookkeeping.
    logic [ENTRIES-1:0]         r_valid;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_cap;
    logic [CNT_W-1:0]           n_cap;

    // Memory and unit signals.
    logic [KEY_BITS-1:0]        key_rd;
    logic [VALUE_BITS-1:0]      value_rd;
    logic [RANK_W-1:0]          rank_rd;
    logic                       key_we;
    logic                       value_we;
    logic [IDX_W-1:0]           value_waddr;
    logic                       rank_we;
    logic [RANK_W-1:0]          new_rank;
    logic [CNT_W-1:0]           count_m1;
    lkvc_pkg::t_scan_hit        scan_hit;

    logic                       in_accept;
    logic                       out_free;
    logic                       evict_now;
    logic [IDX_W-1:0]           ins_slot;
    logic                       scan_last;
    logic                       upd_last;

    // Handshakes.
    assign o_stall     = (r_state != S_IDLE);
    assign in_accept   = i_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    assign scan_last = (r_state == S_SCAN) && r_pend && (r_pidx == LAST_IDX);
    assign upd_last  = (r_state == S_UPD) && r_pend && (r_pidx == LAST_IDX);

    // Capacity write clamped to the store size.
    always_comb begin
        if (i_cfg_data == '0) begin
            n_cap = CNT_W'(1);
        end else if (32'(i_cfg_data) > ENTRIES) begin
            n_cap = CNT_W'(ENTRIES);
        end else begin
            n_cap = CNT_W'(i_cfg_data);
        end
    end

    // Insertion choice: evict the oldest entry when full, reuse the lowest free slot.
    assign count_m1  = r_count - CNT_W'(1);
    assign evict_now = (r_count >= r_cap) && (r_count != '0) && r_lru_found;
    always_comb begin
        if (evict_now && !(r_free_found && (r_free_slot < r_lru_slot))) begin
            ins_slot = r_lru_slot;
        end else begin
            ins_slot = r_free_slot;
        end
    end

    // Memory write enables.
    assign key_we   = (r_state == S_DECIDE) && (r_cmd == lkvc_pkg::CMD_PUT) && !r_found;
    assign value_we = (r_state == S_DECIDE) && (r_cmd == lkvc_pkg::CMD_PUT);
    assign value_waddr = r_found ? r_slot : ins_slot;
    assign rank_we  = (r_state == S_UPD) && r_pend;

    lkvc_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (ins_slot),
        .i_wdata (r_key),
        .i_re    (r_issue),
        .i_raddr (r_idx),
        .o_rdata (key_rd)
    );

    lkvc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (value_we),
        .i_waddr (value_waddr),
        .i_wdata (r_value),
        .i_re    (r_issue),
        .i_raddr (r_idx),
        .o_rdata (value_rd)
    );

    lkvc_ram #(
        .WIDTH (RANK_W),
        .DEPTH (ENTRIES)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (r_pidx),
        .i_wdata (new_rank),
        .i_re    (r_issue),
        .i_raddr (r_idx),
        .o_rdata (rank_rd)
    );

    // Shared compare and rank unit, one entry per cycle.
    lkvc_rank_unit #(
        .KEY_BITS (KEY_BITS),
        .RANK_W   (RANK_W)
    ) u_rank_unit (
        .i_op          (r_op),
        .i_ref_rank    (r_ref_rank),
        .i_lru_rank    (count_m1[RANK_W-1:0]),
        .i_key_req     (r_key),
        .i_key_rd      (key_rd),
        .i_rank_rd     (rank_rd),
        .i_entry_valid (r_valid[r_pidx]),
        .i_is_target   (r_pidx == r_tslot),
        .o_hit         (scan_hit),
        .o_new_rank    (new_rank)
    );

    // Sequencer and entry bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issue      <= 1'b0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_lru_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_op         <= lkvc_pkg::OP_NONE;
            r_valid      <= '0;
            r_count      <= '0;
            r_cap        <= CNT_W'(ENTRIES);
            r_out_valid  <= 1'b0;
        end else begin
            // Read pipeline follows the issued address in the next cycle.
            r_pend <= r_issue;
            if (r_issue && r_idx == LAST_IDX) begin
                r_issue <= 1'b0;
            end

            // Capacity register, only while the store is empty.
            if (i_cfg_valid && o_cfg_ready && r_count == '0) begin
                r_cap <= n_cap;
            end

            // Result word leaves the output register unless a new one replaces it.
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state      <= S_SCAN;
                        r_issue      <= 1'b1;
                        r_found      <= 1'b0;
                        r_lru_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        r_op         <= lkvc_pkg::OP_NONE;
                    end
                end
                S_SCAN: begin
                    if (r_pend) begin
                        if (scan_hit.match && !r_found) begin
                            r_found <= 1'b1;
                        end
                        if (scan_hit.lru && !r_lru_found) begin
                            r_lru_found <= 1'b1;
                        end
                        if (scan_hit.free && !r_free_found) begin
                            r_free_found <= 1'b1;
                        end
                    end
                    if (scan_last) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    unique case (r_cmd)
                        lkvc_pkg::CMD_PUT: begin
                            if (r_found) begin
                                r_op <= lkvc_pkg::OP_PROMOTE;
                            end else begin
                                r_op <= lkvc_pkg::OP_INSERT;
                                if (evict_now) begin
                                    // The victim slot is freed unless it is reused at once.
                                    if (ins_slot != r_lru_slot) begin
                                        r_valid[r_lru_slot] <= 1'b0;
                                    end
                                end else begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                                r_valid[ins_slot] <= 1'b1;
                            end
                            r_state <= S_UPD;
                            r_issue <= 1'b1;
                        end
                        lkvc_pkg::CMD_GET: begin
                            if (r_found) begin
                                r_op    <= lkvc_pkg::OP_PROMOTE;
                                r_state <= S_UPD;
                                r_issue <= 1'b1;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        lkvc_pkg::CMD_REMOVE: begin
                            if (r_found) begin
                                r_op           <= lkvc_pkg::OP_DROP;
                                r_valid[r_slot] <= 1'b0;
                                r_count        <= count_m1;
                                r_state        <= S_UPD;
                                r_issue        <= 1'b1;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        default: begin
                            r_op    <= lkvc_pkg::OP_NONE;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_UPD: begin
                    if (upd_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request word, search captures and result fields.
    always_ff @(posedge i_clk) begin
        if (r_issue) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        r_pidx <= r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_cmd       <= i_cmd;
                    r_key       <= i_key;
                    r_value     <= i_value;
                    r_idx       <= '0;
                    r_hit       <= 1'b0;
                    r_res_value <= '0;
                    r_ev_valid  <= 1'b0;
                    r_ev_key    <= '0;
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (scan_hit.match && !r_found) begin
                        r_slot      <= r_pidx;
                        r_slot_rank <= rank_rd;
                        r_rd_value  <= value_rd;
                    end
                    if (scan_hit.lru && !r_lru_found) begin
                        r_lru_slot <= r_pidx;
                        r_lru_key  <= key_rd;
                    end
                    if (scan_hit.free && !r_free_found) begin
                        r_free_slot <= r_pidx;
                    end
                end
            end
            S_DECIDE: begin
                r_idx      <= '0;
                r_tslot    <= r_found ? r_slot : ins_slot;
                r_ref_rank <= r_slot_rank;
                if (r_found && r_cmd != lkvc_pkg::CMD_PUT && r_cmd != lkvc_pkg::CMD_GET
                        && r_cmd != lkvc_pkg::CMD_REMOVE) begin
                    r_hit <= 1'b0;
                end else begin
                    r_hit <= r_found;
                end
                if (r_found && r_cmd == lkvc_pkg::CMD_GET) begin
                    r_res_value <= r_rd_value;
                end
                if (!r_found && r_cmd == lkvc_pkg::CMD_PUT && evict_now) begin
                    r_ev_valid <= 1'b1;
                    r_ev_key   <= r_lru_key;
                end
            end
            S_UPD: begin
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_hit      <= r_hit;
                    r_out_value    <= r_res_value;
                    r_out_ev_valid <= r_ev_valid;
                    r_out_ev_key   <= r_ev_key;
                end
            end
            default: begin
            end
        endcase
    end

    // Result word.
    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_read_value    = r_out_value;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_victim_key    = r_out_ev_key;

endmodule

### tb/lru_key_value_cache_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_test: self-checking bench of the LRU key/value cache
// Requests go in one word at a time. A behavioral copy of the cache predicts
// every result word, and each returned word is checked field by field.
// Directed cases cover the edges of the fields and the capacity register.
// Random phases follow with different capacities, idle bursts and a long
// result stall.
// ----------------------------------------------------------------------------
module lru_key_value_cache_test;

    localparam int ENTRIES        = 16;
    localparam int KEY_BITS       = 64;
    localparam int VALUE_BITS     = 64;
    localparam int CFG_BITS       = lkvc_pkg::CFG_W;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int LONG_HOLD      = 400;
    localparam logic [lkvc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted_valid;
        logic [KEY_BITS-1:0]   victim_key;
    } t_lookup_reply;

    // Clock, reset and block ports.
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [lkvc_pkg::CMD_W-1:0]  i_cmd = '0;
    logic [KEY_BITS-1:0]         i_key = '0;
    logic [VALUE_BITS-1:0]       i_value = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic                        o_hit;
    logic [VALUE_BITS-1:0]       o_read_value;
    logic                        o_evicted_valid;
    logic [KEY_BITS-1:0]         o_victim_key;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [lkvc_pkg::CFG_W-1:0]  i_cfg_data = '0;

    // Behavioral copy of the cache contents.
    logic [KEY_BITS-1:0]   cache_key [ENTRIES];
    logic [VALUE_BITS-1:0] cache_value [ENTRIES];
    bit                    cache_used [ENTRIES];
    int unsigned           cache_rank [ENTRIES];
    int unsigned           cache_count;
    int unsigned           shadow_limit;

    // Replies predicted but not yet returned, oldest first.
    t_lookup_reply reply_queue[$];

    int  fail_count = 0;
    int  quiet_cycles = 0;
    bit  send_idle_on = 1'b0;
    bit  recv_idle_on = 1'b0;
    int  hold_len = 0;

    lru_key_value_cache #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_key           (i_key),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_read_value    (o_read_value),
        .o_evicted_valid (o_evicted_valid),
        .o_victim_key    (o_victim_key),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Move an entry to the most recent rank, aging the ones that were newer.
    function automatic void promote_entry(input int slot);
        int unsigned old_rank;
        old_rank = cache_rank[slot];
        for (int i = 0; i < ENTRIES; i++) begin
            if (cache_used[i] && cache_rank[i] < old_rank) cache_rank[i]++;
        end
        cache_rank[slot] = 0;
    endfunction

    // Free an entry and close the gap it leaves in the ranks.
    function automatic void drop_entry(input int slot);
        int unsigned old_rank;
        old_rank = cache_rank[slot];
        cache_used[slot] = 1'b0;
        cache_rank[slot] = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (cache_used[i] && cache_rank[i] > old_rank) cache_rank[i]--;
        end
        if (cache_count > 0) cache_count--;
    endfunction

    // Apply one request to the copy and return the reply it should produce.
    function automatic t_lookup_reply apply_request(input logic [lkvc_pkg::CMD_W-1:0] cmd,
                                                    input logic [KEY_BITS-1:0] key,
                                                    input logic [VALUE_BITS-1:0] value);
        t_lookup_reply reply;
        int slot;
        int free_slot;
        reply = '0;
        slot = -1;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && cache_used[i] && cache_key[i] == key) slot = i;
        end
        case (cmd)
            lkvc_pkg::CMD_PUT: begin
                if (slot >= 0) begin
                    reply.hit = 1'b1;
                    cache_value[slot] = value;
                    promote_entry(slot);
                end else begin
                    // A full store gives up its least recent entry first.
                    if (cache_count >= shadow_limit && cache_count > 0) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (!reply.evicted_valid && cache_used[i] &&
                                cache_rank[i] == cache_count - 1) begin
                                reply.evicted_valid = 1'b1;
                                reply.victim_key = cache_key[i];
                                drop_entry(i);
                            end
                        end
                    end
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (free_slot < 0 && !cache_used[i]) free_slot = i;
                    end
                    if (free_slot >= 0) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (cache_used[i]) cache_rank[i]++;
                        end
                        cache_used[free_slot] = 1'b1;
                        cache_key[free_slot] = key;
                        cache_value[free_slot] = value;
                        cache_rank[free_slot] = 0;
                        cache_count++;
                    end
                end
            end
            lkvc_pkg::CMD_GET: begin
                if (slot >= 0) begin
                    reply.hit = 1'b1;
                    reply.read_value = cache_value[slot];
                    promote_entry(slot);
                end
            end
            lkvc_pkg::CMD_REMOVE: begin
                if (slot >= 0) begin
                    reply.hit = 1'b1;
                    drop_entry(slot);
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    // Offer one request word and record its reply once it is taken.
    task automatic send_request(input logic [lkvc_pkg::CMD_W-1:0] cmd,
                                input logic [KEY_BITS-1:0] key,
                                input logic [VALUE_BITS-1:0] value);
        int gap;
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_key   <= key;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        reply_queue.push_back(apply_request(cmd, key, value));
        if (send_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering requests and wait until every reply has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (reply_queue.size() != 0);
    endtask

    // Write the capacity register; the block takes it only while empty.
    task automatic write_capacity(input logic [lkvc_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (cache_count == 0) begin
            if (data == 0) shadow_limit = 1;
            else if (data > ENTRIES) shadow_limit = ENTRIES;
            else shadow_limit = data;
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Remove every key still held so that the capacity can be changed.
    task automatic clear_store();
        int slot;
        while (cache_count > 0) begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && cache_used[i]) slot = i;
            end
            send_request(lkvc_pkg::CMD_REMOVE, cache_key[slot], {$urandom, $urandom});
        end
        wait_drained();
    endtask

    // Extreme keys and values, every request kind and the unused code.
    task automatic test_basic_requests();
        send_request(lkvc_pkg::CMD_PUT, '0, '0);
        send_request(lkvc_pkg::CMD_PUT, '1, '1);
        send_request(lkvc_pkg::CMD_GET, '0, '1);
        send_request(lkvc_pkg::CMD_GET, '1, '0);
        send_request(lkvc_pkg::CMD_GET, 64'h5a5a_a5a5_0f0f_f0f0, '0);
        send_request(lkvc_pkg::CMD_PUT, '0, 64'h0123_4567_89ab_cdef);
        send_request(lkvc_pkg::CMD_GET, '0, '0);
        send_request(CMD_UNUSED, '1, '1);
        send_request(lkvc_pkg::CMD_REMOVE, '1, '0);
        send_request(lkvc_pkg::CMD_REMOVE, '1, '0);
        send_request(lkvc_pkg::CMD_GET, '1, '0);
        wait_drained();
    endtask

    // Smallest capacity, a write refused while entries remain, and clamping.
    task automatic test_capacity_limits();
        clear_store();
        write_capacity(5'd0);
        send_request(lkvc_pkg::CMD_PUT, 64'h1111_0000_0000_0001, 64'hdead_beef_0000_0001);
        send_request(lkvc_pkg::CMD_PUT, 64'h2222_0000_0000_0002, 64'hdead_beef_0000_0002);
        send_request(lkvc_pkg::CMD_GET, 64'h1111_0000_0000_0001, '0);
        wait_drained();
        write_capacity(5'd31);
        send_request(lkvc_pkg::CMD_PUT, 64'h3333_0000_0000_0003, 64'hdead_beef_0000_0003);
        send_request(lkvc_pkg::CMD_GET, 64'h2222_0000_0000_0002, '0);
        clear_store();
        write_capacity(5'd31);
    endtask

    // Hold the result side off for a long time while requests keep coming.
    task automatic test_back_pressure();
        logic [KEY_BITS-1:0] pool [4];
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        foreach (pool[i]) pool[i] = {$urandom, $urandom};
        hold_len = LONG_HOLD;
        for (int n = 0; n < 30; n++) begin
            send_request($urandom_range(0, 1) ? lkvc_pkg::CMD_PUT : lkvc_pkg::CMD_GET,
                         pool[$urandom_range(0, 3)], {$urandom, $urandom});
        end
        wait_drained();
    endtask

    // Random requests over a small key pool so hits and evictions are common.
    task automatic test_random_traffic(input logic [lkvc_pkg::CFG_W-1:0] capacity_word,
                                       input int n_items, input bit with_idle);
        logic [KEY_BITS-1:0]         pool [24];
        logic [lkvc_pkg::CMD_W-1:0]  cmd;
        logic [KEY_BITS-1:0]         key;
        int                          pool_size;
        int                          pick;
        clear_store();
        write_capacity(capacity_word);
        pool_size = shadow_limit + $urandom_range(1, 6);
        if (pool_size > 24) pool_size = 24;
        foreach (pool[i]) pool[i] = {$urandom, $urandom};
        for (int n = 0; n < n_items; n++) begin
            // Idling comes and goes in stretches of forty requests.
            if (n % 40 == 0) begin
                send_idle_on = with_idle && ($urandom_range(0, 2) != 0);
                recv_idle_on = with_idle && ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) cmd = lkvc_pkg::CMD_PUT;
            else if (pick < 75) cmd = lkvc_pkg::CMD_GET;
            else if (pick < 95) cmd = lkvc_pkg::CMD_REMOVE;
            else cmd = CMD_UNUSED;
            pick = $urandom_range(0, 99);
            key = pool[$urandom_range(0, pool_size - 1)];
            // Near misses differ from a stored key in a single bit.
            if (pick >= 90) key = {$urandom, $urandom};
            else if (pick >= 80) key[$urandom_range(0, KEY_BITS - 1)] ^= 1'b1;
            send_request(cmd, key, {$urandom, $urandom});
        end
        wait_drained();
    endtask

    // Result side stall: random bursts, or one long hold when asked.
    initial begin : result_stall_gen
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 5);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Check every result word taken against the oldest prediction.
    always @(posedge i_clk) begin
        t_lookup_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reply_queue.size() == 0) begin
                $display("%0t: result word with none expected: hit %b value %h ev %b key %h",
                         $time, o_hit, o_read_value, o_evicted_valid, o_victim_key);
                fail_count++;
            end else begin
                want = reply_queue.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, o_hit);
                    fail_count++;
                end
                if (o_read_value !== want.read_value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, o_read_value);
                    fail_count++;
                end
                if (o_evicted_valid !== want.evicted_valid) begin
                    $display("%0t: evicted_valid expected %b actual %b",
                             $time, want.evicted_valid, o_evicted_valid);
                    fail_count++;
                end
                if (o_victim_key !== want.victim_key) begin
                    $display("%0t: victim_key expected %h actual %h",
                             $time, want.victim_key, o_victim_key);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            cache_key[i] = '0;
            cache_value[i] = '0;
            cache_used[i] = 1'b0;
            cache_rank[i] = 0;
        end
        cache_count = 0;
        shadow_limit = ENTRIES;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        test_basic_requests();
        test_capacity_limits();
        test_back_pressure();
        test_random_traffic(5'd16, 180, 1'b1);
        test_random_traffic(5'd1, 150, 1'b1);
        test_random_traffic(5'd2, 150, 1'b1);
        test_random_traffic(5'd31, 180, 1'b1);
        test_random_traffic(CFG_BITS'($urandom_range(3, 15)), 180, 1'b1);
        // Last stretch runs at full rate on both sides.
        test_random_traffic(5'd16, 180, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && reply_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
src/lkvc_pkg.sv
src/lkvc_ram.sv
src/lkvc_rank_unit.sv
src/lru_key_value_cache.sv
tb/lru_key_value_cache_test.sv
